/* design/assert_macros.svh */
// Concurrent check macros; clk and rst are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_SAME(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif

`endif

/* design/beqcs_pkg.sv */
`default_nettype none

package beqcs_pkg;

  localparam int WORD_W          = 32;
  localparam int LANE_COUNT      = 32;
  localparam int BLOCK_VALUES    = 1024;
  localparam int VALUES_PER_LANE = BLOCK_VALUES / LANE_COUNT;
  localparam int ROW_W           = $clog2(WORD_W);
  localparam int BW_W            = 6;
  localparam int CNT_W           = 64;
  localparam int BLK_W           = 16;
  localparam int LCNT_W          = $clog2(VALUES_PER_LANE + 1);
  localparam int POS_W           = 2 * ROW_W + 1;
  localparam int CFG_IDX_W       = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_WIDTH    = 1'b0,
    REG_TARGET_VALUE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic blk_end;
    logic last;
  } flags_t;

  typedef struct packed {
    logic ld2;
    logic ready1;
    logic emit;
  } ctrl_t;

  // bit j set when some value of a lane ends at bit j of the given row
  function automatic logic [WORD_W-1:0] end_mask(input logic [BW_W-1:0] b,
                                                 input logic [ROW_W-1:0] row);
    logic [WORD_W-1:0] m;
    logic [POS_W-1:0]  e;
    m = '0;
    for (int p = 0; p < VALUES_PER_LANE; p++) begin
      e = POS_W'(p + 1) * POS_W'(b) - POS_W'(1);
      if (e[2*ROW_W-1:ROW_W] == row) m[e[ROW_W-1:0]] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* design/beqcs_front.sv */
`default_nettype none

module beqcs_front
  import beqcs_pkg::*;
#(
  parameter int WORDS_PER_ITEM = 4
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]                   cfg_index,
  input  wire  [WORD_W-1:0]                      cfg_data,
  input  wire                                    s_tvalid,
  output logic                                   s_tready,
  input  wire  [WORDS_PER_ITEM*WORD_W-1:0]       s_tdata,
  input  wire                                    s_tlast,
  input  ctrl_t                                  ctrl,
  output logic                                   v1,
  output logic [WORDS_PER_ITEM-1:0][WORD_W-1:0]  cur1,
  output logic [WORDS_PER_ITEM-1:0][WORD_W-1:0]  prev1,
  output logic [WORD_W-1:0]                      emask1,
  output logic [WORD_W-1:0]                      tt1,
  output logic [WORD_W-1:0]                      mm1,
  output logic [WORDS_PER_ITEM-1:0]              lane_ok1,
  output flags_t                                 flags1
);

  localparam int GROUPS = (LANE_COUNT + WORDS_PER_ITEM - 1) / WORDS_PER_ITEM;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [BW_W-1:0]   bit_width;
  logic [WORD_W-1:0] target_value;
  logic [ROW_W-1:0]  row;
  logic [GRP_W-1:0]  grp;
  logic [WORDS_PER_ITEM-1:0][WORD_W-1:0] prev_mem [GROUPS];

  logic                      accept;
  logic [BW_W-1:0]           b_used;
  logic                      row_end;
  logic                      blk_end;
  logic [WORD_W-1:0]         mm_c;
  logic [WORD_W-1:0]         tt_c;
  logic [WORDS_PER_ITEM-1:0] lane_ok_c;

  assign s_tready = ctrl.ready1;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (bit_width == '0) begin
      b_used = BW_W'(1);
    end else if (bit_width > BW_W'(WORD_W)) begin
      b_used = BW_W'(WORD_W);
    end else begin
      b_used = bit_width;
    end
  end

  // value field aligned to the top of a 32-bit window
  assign mm_c = ~({WORD_W{1'b1}} >> b_used);
  assign tt_c = target_value << (BW_W'(WORD_W) - b_used);

  assign row_end = (grp == GRP_W'(GROUPS - 1));
  assign blk_end = row_end && ((BW_W'(row) + BW_W'(1)) >= b_used);

  always_comb begin
    for (int i = 0; i < WORDS_PER_ITEM; i++) begin
      lane_ok_c[i] = (32'(grp) * 32'(WORDS_PER_ITEM) + 32'(i)) < 32'(LANE_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      bit_width    <= BW_W'(1);
      target_value <= '0;
      row          <= '0;
      grp          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BIT_WIDTH:    bit_width    <= cfg_data[BW_W-1:0];
          REG_TARGET_VALUE: target_value <= cfg_data;
          default:          ;
        endcase
      end
      if (accept) begin
        v1 <= 1'b1;
        if (s_tlast) begin
          row <= '0;
          grp <= '0;
        end else if (row_end) begin
          grp <= '0;
          row <= blk_end ? '0 : row + ROW_W'(1);
        end else begin
          grp <= grp + GRP_W'(1);
        end
      end else if (ctrl.ld2) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur1          <= s_tdata;
      prev1         <= prev_mem[grp];
      prev_mem[grp] <= s_tdata;
      emask1        <= end_mask(b_used, row);
      tt1           <= tt_c;
      mm1           <= mm_c;
      lane_ok1      <= lane_ok_c;
      flags1        <= '{blk_end: blk_end, last: s_tlast};
    end
  end

endmodule

`default_nettype wire

/* design/beqcs_lane.sv */
`default_nettype none

module beqcs_lane
  import beqcs_pkg::*;
(
  input  wire                clk,
  input  wire                en,
  input  wire                lane_ok,
  input  wire  [WORD_W-1:0]  cur,
  input  wire  [WORD_W-1:0]  prev,
  input  wire  [WORD_W-1:0]  emask,
  input  wire  [WORD_W-1:0]  tt,
  input  wire  [WORD_W-1:0]  mm,
  output logic [LCNT_W-1:0]  cnt
);

  logic [2*WORD_W-1:0] win;
  logic [WORD_W-1:0]   hit;

  assign win = {cur, prev};

  // value ending at bit j occupies the top of win[j+32:j+1]
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      hit[j] = emask[j] && (((win[j+WORD_W -: WORD_W] ^ tt) & mm) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt <= lane_ok ? LCNT_W'($countones(hit)) : '0;
    end
  end

endmodule

`default_nettype wire

/* design/beqcs_merge.sv */
`default_nettype none

module beqcs_merge
  import beqcs_pkg::*;
#(
  parameter int WORDS_PER_ITEM = 4
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    v1,
  input  flags_t                                 flags1,
  input  wire  [WORDS_PER_ITEM-1:0][LCNT_W-1:0]  lane_cnt,
  output ctrl_t                                  ctrl,
  output logic                                   m_tvalid,
  input  wire                                    m_tready,
  output logic [CNT_W-1:0]                       m_tdata
);

  localparam int SUM_W = $clog2(WORDS_PER_ITEM * VALUES_PER_LANE + 1);

  logic             v2;
  logic             v3;
  flags_t           flags2;
  flags_t           flags3;
  logic [SUM_W-1:0] sum3;
  logic [BLK_W-1:0] blk;
  logic [CNT_W-1:0] total;

  logic             fire3;
  logic             ready2;
  logic             ready3;
  logic             ld3;
  logic [SUM_W-1:0] sum_c;
  logic [BLK_W-1:0] blk_sum;
  logic [BLK_W-1:0] blk_next;
  logic [CNT_W-1:0] total_next;

  assign fire3       = v3 && (!flags3.last || !m_tvalid || m_tready);
  assign ready3      = !v3 || fire3;
  assign ld3         = v2 && ready3;
  assign ready2      = !v2 || ready3;
  assign ctrl.ld2    = v1 && ready2;
  assign ctrl.ready1 = !v1 || ready2;
  assign ctrl.emit   = fire3 && flags3.last;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < WORDS_PER_ITEM; i++) begin
      sum_c = sum_c + SUM_W'(lane_cnt[i]);
    end
  end

  always_comb begin
    blk_sum = blk + BLK_W'(sum3);
    if (flags3.blk_end) begin
      total_next = total + CNT_W'(blk_sum);
      blk_next   = '0;
    end else begin
      total_next = total;
      blk_next   = blk_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
      blk      <= '0;
      total    <= '0;
    end else begin
      if (ctrl.ld2) begin
        v2 <= 1'b1;
      end else if (ld3) begin
        v2 <= 1'b0;
      end
      if (ld3) begin
        v3 <= 1'b1;
      end else if (fire3) begin
        v3 <= 1'b0;
      end
      if (fire3) begin
        if (flags3.last) begin
          total <= '0;
          blk   <= '0;
        end else begin
          total <= total_next;
          blk   <= blk_next;
        end
      end
      if (ctrl.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      flags2 <= flags1;
    end
    if (ld3) begin
      flags3 <= flags2;
      sum3   <= sum_c;
    end
    if (ctrl.emit) begin
      m_tdata <= total_next;
    end
  end

endmodule

`default_nettype wire

/* design/bitpacked_equality_count_scan_unit.sv */
`default_nettype none
// Equality count over a bit-transposed packed column.
// Input stream: each transaction carries WORDS_PER_ITEM lane words of one row;
// transactions walk the lane groups of a row, then the rows of a block
// (bit_width rows per 1024-value block). s_tlast marks the final transaction
// of a scan. The output stream carries one 64-bit count per final transaction:
// the matches found in completed blocks; a trailing partial block is dropped.
// Configuration: cfg_we with cfg_index 0 writes bit_width, index 1 writes
// target_value; write only while the block is idle.
// Throughput: one transaction per cycle when not stalled. Each of the
// WORDS_PER_ITEM lanes checks the 32 value end positions of its word at once,
// and a merge stage adds the lane counts into the block and total counters.
// Path: after the final transaction is accepted, the count passes through
// capture, lane compare, lane sum and accumulate into the output register.
// Stall: while a count waits on m_tready, non-final transactions keep flowing
// into the accumulators; s_tready drops once a second final transaction waits
// in the accumulate stage and the two stages behind it are full.
// Reset: bit_width returns to 1, target_value to 0, counts and positions clear.
`include "assert_macros.svh"

module bitpacked_equality_count_scan_unit
  import beqcs_pkg::*;
#(
  parameter int WORDS_PER_ITEM = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [CFG_IDX_W-1:0]              cfg_index,
  input  wire  [WORD_W-1:0]                 cfg_data,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // word_a, word_b, word_c, word_d, ... (32 bits each, lowest first)
  input  wire  [WORDS_PER_ITEM*WORD_W-1:0]  s_tdata,
  input  wire                               s_tlast,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // match_count
  output logic [CNT_W-1:0]                  m_tdata
);

  ctrl_t                                  ctrl;
  logic                                   v1;
  logic [WORDS_PER_ITEM-1:0][WORD_W-1:0]  cur1;
  logic [WORDS_PER_ITEM-1:0][WORD_W-1:0]  prev1;
  logic [WORD_W-1:0]                      emask1;
  logic [WORD_W-1:0]                      tt1;
  logic [WORD_W-1:0]                      mm1;
  logic [WORDS_PER_ITEM-1:0]              lane_ok1;
  flags_t                                 flags1;
  logic [WORDS_PER_ITEM-1:0][LCNT_W-1:0]  lane_cnt;

  beqcs_front #(
    .WORDS_PER_ITEM(WORDS_PER_ITEM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .ctrl     (ctrl),
    .v1       (v1),
    .cur1     (cur1),
    .prev1    (prev1),
    .emask1   (emask1),
    .tt1      (tt1),
    .mm1      (mm1),
    .lane_ok1 (lane_ok1),
    .flags1   (flags1)
  );

  for (genvar i = 0; i < WORDS_PER_ITEM; i++) begin : g_lane
    beqcs_lane u_lane (
      .clk    (clk),
      .en     (ctrl.ld2),
      .lane_ok(lane_ok1[i]),
      .cur    (cur1[i]),
      .prev   (prev1[i]),
      .emask  (emask1),
      .tt     (tt1),
      .mm     (mm1),
      .cnt    (lane_cnt[i])
    );
  end

  beqcs_merge #(
    .WORDS_PER_ITEM(WORDS_PER_ITEM)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .v1      (v1),
    .flags1  (flags1),
    .lane_cnt(lane_cnt),
    .ctrl    (ctrl),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  `CHK_SAME(a_out_from_final, $rose(m_tvalid), $past(ctrl.emit))
  `CHK_SAME(a_stall_needs_item, !s_tready, v1)
  `CHK_SAME(a_emit_has_slot, ctrl.emit, !m_tvalid || m_tready)

endmodule

`default_nettype wire
